@@ rtl/rua_pkg.sv @@
// Package for the region unpack address scanner.
// Holds the command and result types, op and kind codes and coordinate constants.
// No dependencies; every module of the block imports it.
package rua_pkg;

    localparam int COORD_BITS = 16;
    localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

    localparam int NUM_KINDS  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

    // Op codes on the input stream.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Region kinds and target planes.
    localparam logic [1:0] KIND_OCC  = 2'd0;
    localparam logic [1:0] KIND_GEO  = 2'd1;
    localparam logic [1:0] KIND_ATTR = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_STEP,
        CMD_CLEAR,
        CMD_NOP
    } cmd_op_t;

    // Decoded request handed from the front end to the scan engine.
    typedef struct packed {
        cmd_op_t     op;
        logic [1:0]  kind;
        logic        rot;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] ux;
        logic [15:0] uy;
        logic [16:0] ex;
        logic [16:0] ey;
    } cmd_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic        pair_valid;
        logic [16:0] src_x;
        logic [16:0] src_y;
        logic [16:0] dst_x;
        logic [16:0] dst_y;
        logic [1:0]  target_plane;
        logic        region_done;
        logic [16:0] extent_width;
        logic [16:0] extent_height;
    } result_t;

endpackage

@@ rtl/region_unpack_address_scanner.sv @@
// Top level of the region unpack address scanner.
// Instantiates rua_front, rua_cmd_queue and rua_scan_engine; depends on rua_pkg.
//
// Usage: each request on the slave stream carries an op in s_tuser (load a
// region descriptor, step the scan, or clear the component extents) and the
// descriptor fields in s_tdata. Every request yields exactly one result on
// the master stream, in request order. A step during a scan returns a
// source/destination coordinate pair with pair_valid set in m_tuser; m_tlast
// marks the last pair of a region. Other results carry no pair but report the
// latched target plane and its current extent.
// Each request passes the decode register, the command queue and the result
// register on its way to m_tvalid. Throughput is one request per cycle while
// m_tready does not hold back the result register; the scan engine updates
// its scan counters and extents with each request it accepts.
// The four-entry command queue decouples the two sides: while m_tready is low
// the queue fills and s_tready drops only once queue and decode register are
// full. Reset clears the queue, the scan state and all extents; no clearing
// pass is needed.
module region_unpack_address_scanner (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low bit up: packed_x[15:0], packed_y[15:0], region_width[15:0],
    // region_height[15:0], unpacked_x[15:0], unpacked_y[15:0], rotated, 7 zero bits
    input  logic [103:0] s_tdata,
    // s_tuser, low bit up: op[1:0], region_kind[1:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low bit up: src_x[16:0], src_y[16:0], dst_x[16:0], dst_y[16:0],
    // extent_width[16:0], extent_height[16:0], 2 zero bits
    output logic [103:0] m_tdata,
    // m_tuser, low bit up: pair_valid, target_plane[1:0]
    output logic [2:0]   m_tuser,
    // m_tlast: region_done
    output logic         m_tlast
);
    import rua_pkg::*;

    logic    front_valid;
    logic    front_ready;
    cmd_t    front_cmd;
    logic    q_valid;
    logic    q_ready;
    cmd_t    q_cmd;
    result_t res;

    rua_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .op            (s_tuser[1:0]),
        .region_kind   (s_tuser[3:2]),
        .packed_x      (s_tdata[15:0]),
        .packed_y      (s_tdata[31:16]),
        .region_width  (s_tdata[47:32]),
        .region_height (s_tdata[63:48]),
        .unpacked_x    (s_tdata[79:64]),
        .unpacked_y    (s_tdata[95:80]),
        .rotated       (s_tdata[96]),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    rua_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    rua_scan_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {2'b00, res.extent_height, res.extent_width, res.dst_y, res.dst_x,
                      res.src_y, res.src_x};
    assign m_tuser = {res.target_plane, res.pair_valid};
    assign m_tlast = res.region_done;

endmodule

@@ rtl/rua_front.sv @@
// Front end of the region unpack address scanner: takes input requests,
// decodes the op, masks coordinates and precomputes the unpacked extent.
// Depends on rua_pkg.
module rua_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     op,
    input  logic [1:0]     region_kind,
    input  logic [15:0]    packed_x,
    input  logic [15:0]    packed_y,
    input  logic [15:0]    region_width,
    input  logic [15:0]    region_height,
    input  logic [15:0]    unpacked_x,
    input  logic [15:0]    unpacked_y,
    input  logic           rotated,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output rua_pkg::cmd_t  cmd
);
    import rua_pkg::*;

    logic        valid_reg;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [15:0] w_fix;
    logic [15:0] h_fix;
    logic [15:0] ux_m;
    logic [15:0] uy_m;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        w_fix = region_width & COORD_MASK;
        h_fix = region_height & COORD_MASK;
        if (w_fix == 16'd0)
        begin
            w_fix = 16'd1;
        end
        if (h_fix == 16'd0)
        begin
            h_fix = 16'd1;
        end
        ux_m = unpacked_x & COORD_MASK;
        uy_m = unpacked_y & COORD_MASK;

        unique case (op)
            OP_LOAD:  cmd_next.op = CMD_LOAD;
            OP_STEP:  cmd_next.op = CMD_STEP;
            OP_CLEAR: cmd_next.op = CMD_CLEAR;
            default:  cmd_next.op = CMD_NOP;
        endcase
        cmd_next.kind = region_kind;
        cmd_next.rot  = rotated;
        cmd_next.px   = packed_x & COORD_MASK;
        cmd_next.py   = packed_y & COORD_MASK;
        cmd_next.w    = w_fix;
        cmd_next.h    = h_fix;
        cmd_next.ux   = ux_m;
        cmd_next.uy   = uy_m;
        // A rotated region covers height columns and width rows in the unpacked frame.
        cmd_next.ex   = {1'b0, ux_m} + {1'b0, (rotated ? h_fix : w_fix)};
        cmd_next.ey   = {1'b0, uy_m} + {1'b0, (rotated ? w_fix : h_fix)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ rtl/rua_cmd_queue.sv @@
// Short command queue between the front end and the scan engine.
// A small register-file FIFO with a fill count; depends on rua_pkg.
module rua_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rua_pkg::cmd_t  push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rua_pkg::cmd_t  pop_cmd
);
    import rua_pkg::*;

    cmd_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/rua_scan_engine.sv @@
// Scan engine of the region unpack address scanner: holds the descriptor,
// scan counters and component extents, and registers one result per request.
// Depends on rua_pkg.
module rua_scan_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rua_pkg::cmd_t     cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output rua_pkg::result_t  res
);
    import rua_pkg::*;

    logic        out_valid_reg;
    result_t     res_reg;
    result_t     res_next;

    logic [15:0] px_reg, py_reg, w_reg, h_reg, ux_reg, uy_reg;
    logic [15:0] px_next, py_next, w_next, h_next, ux_next, uy_next;
    logic [1:0]  kind_reg, kind_next;
    logic        rot_reg, rot_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic        active_reg, active_next;
    logic [16:0] ext_w_reg  [NUM_KINDS];
    logic [16:0] ext_h_reg  [NUM_KINDS];
    logic [16:0] ext_w_next [NUM_KINDS];
    logic [16:0] ext_h_next [NUM_KINDS];

    logic        fire;
    logic [1:0]  sel_kind;
    logic        sel_ok;
    logic [16:0] cur_w, cur_h;
    logic [16:0] grow_w, grow_h;
    logic        last_row, last_col;
    logic [16:0] row_inc, col_inc;

    assign cmd_ready = !out_valid_reg || res_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        sel_kind = (cmd.op == CMD_LOAD) ? cmd.kind : kind_reg;
        sel_ok   = (sel_kind != KIND_NONE);
        case (sel_kind)
            KIND_OCC:
            begin
                cur_w = ext_w_reg[0];
                cur_h = ext_h_reg[0];
            end
            KIND_GEO:
            begin
                cur_w = ext_w_reg[1];
                cur_h = ext_h_reg[1];
            end
            KIND_ATTR:
            begin
                cur_w = ext_w_reg[2];
                cur_h = ext_h_reg[2];
            end
            default:
            begin
                cur_w = '0;
                cur_h = '0;
            end
        endcase
        grow_w   = (cmd.ex > cur_w) ? cmd.ex : cur_w;
        grow_h   = (cmd.ey > cur_h) ? cmd.ey : cur_h;
        row_inc  = {1'b0, row_reg} + 17'd1;
        col_inc  = {1'b0, col_reg} + 17'd1;
        last_row = (row_inc >= {1'b0, h_reg});
        last_col = (col_inc >= {1'b0, w_reg});

        px_next     = px_reg;
        py_next     = py_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        ux_next     = ux_reg;
        uy_next     = uy_reg;
        kind_next   = kind_reg;
        rot_next    = rot_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        active_next = active_reg;
        ext_w_next  = ext_w_reg;
        ext_h_next  = ext_h_reg;

        res_next               = '0;
        res_next.target_plane  = sel_kind;
        res_next.extent_width  = cur_w;
        res_next.extent_height = cur_h;

        case (cmd.op)
            CMD_LOAD:
            begin
                px_next     = cmd.px;
                py_next     = cmd.py;
                w_next      = cmd.w;
                h_next      = cmd.h;
                ux_next     = cmd.ux;
                uy_next     = cmd.uy;
                kind_next   = cmd.kind;
                rot_next    = cmd.rot;
                col_next    = '0;
                row_next    = '0;
                active_next = sel_ok;
                if (sel_ok)
                begin
                    for (int i = 0; i < NUM_KINDS; i++)
                    begin
                        if (2'(i) == sel_kind)
                        begin
                            ext_w_next[i] = grow_w;
                            ext_h_next[i] = grow_h;
                        end
                    end
                    res_next.extent_width  = grow_w;
                    res_next.extent_height = grow_h;
                end
            end
            CMD_STEP:
            begin
                if (active_reg)
                begin
                    res_next.pair_valid = 1'b1;
                    res_next.src_x = {1'b0, px_reg} + {1'b0, col_reg};
                    res_next.src_y = {1'b0, py_reg} + {1'b0, row_reg};
                    // Rotation swaps the column and row offsets on the destination side.
                    res_next.dst_x = {1'b0, ux_reg} + {1'b0, (rot_reg ? row_reg : col_reg)};
                    res_next.dst_y = {1'b0, uy_reg} + {1'b0, (rot_reg ? col_reg : row_reg)};
                    if (last_row)
                    begin
                        row_next = '0;
                        if (last_col)
                        begin
                            col_next    = '0;
                            active_next = 1'b0;
                            res_next.region_done = 1'b1;
                        end
                        else
                        begin
                            col_next = col_inc[15:0];
                        end
                    end
                    else
                    begin
                        row_next = row_inc[15:0];
                    end
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < NUM_KINDS; i++)
                begin
                    ext_w_next[i] = '0;
                    ext_h_next[i] = '0;
                end
                res_next.extent_width  = '0;
                res_next.extent_height = '0;
            end
            default:
            begin
                res_next.target_plane = kind_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
            ux_reg        <= '0;
            uy_reg        <= '0;
            kind_reg      <= '0;
            rot_reg       <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            active_reg    <= 1'b0;
            for (int i = 0; i < NUM_KINDS; i++)
            begin
                ext_w_reg[i] <= '0;
                ext_h_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd_ready)
            begin
                out_valid_reg <= cmd_valid;
            end
            if (fire)
            begin
                px_reg     <= px_next;
                py_reg     <= py_next;
                w_reg      <= w_next;
                h_reg      <= h_next;
                ux_reg     <= ux_next;
                uy_reg     <= uy_next;
                kind_reg   <= kind_next;
                rot_reg    <= rot_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
                active_reg <= active_next;
                ext_w_reg  <= ext_w_next;
                ext_h_reg  <= ext_h_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

@@ tb/sv/rua_scan_checker.sv @@
// Checker for the region unpack address scanner: watches both stream channels,
// predicts every result from the accepted requests and compares field by field.
// Depends on rua_pkg for the op and kind codes and the result type.
module rua_scan_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rua_pkg::*;

    // Latched descriptor and scan position of the predicted block.
    logic [15:0] reg_px, reg_py, reg_w, reg_h, reg_ux, reg_uy;
    logic [1:0]  lat_kind;
    logic        lat_rot;
    logic [15:0] col, row;
    logic        scanning;
    logic [16:0] ext_w [NUM_KINDS];
    logic [16:0] ext_h [NUM_KINDS];

    result_t expected_pairs [$];

    initial errors = 0;

    function automatic result_t scan_model(input logic [1:0] op, input logic [1:0] kind,
                                           input logic [103:0] d);
        result_t     r;
        logic [15:0] w, h;
        logic [16:0] ex, ey;
        r = '0;
        case (op)
            OP_LOAD:
            begin
                w = d[47:32];
                h = d[63:48];
                // A zero size is taken as one pixel.
                if (w == 16'd0)
                    w = 16'd1;
                if (h == 16'd0)
                    h = 16'd1;
                reg_px = d[15:0];
                reg_py = d[31:16];
                reg_w = w;
                reg_h = h;
                reg_ux = d[79:64];
                reg_uy = d[95:80];
                lat_kind = kind;
                lat_rot = d[96];
                col = 16'd0;
                row = 16'd0;
                scanning = 1'b0;
                if (kind != KIND_NONE)
                begin
                    ex = {1'b0, reg_ux} + {1'b0, lat_rot ? h : w};
                    ey = {1'b0, reg_uy} + {1'b0, lat_rot ? w : h};
                    if (ex > ext_w[kind])
                        ext_w[kind] = ex;
                    if (ey > ext_h[kind])
                        ext_h[kind] = ey;
                    scanning = 1'b1;
                end
            end
            OP_STEP:
            begin
                if (scanning)
                begin
                    r.pair_valid = 1'b1;
                    r.src_x = {1'b0, reg_px} + {1'b0, col};
                    r.src_y = {1'b0, reg_py} + {1'b0, row};
                    r.dst_x = {1'b0, reg_ux} + {1'b0, lat_rot ? row : col};
                    r.dst_y = {1'b0, reg_uy} + {1'b0, lat_rot ? col : row};
                    // Rows run fastest; the column advances when a row sweep ends.
                    if ({1'b0, row} + 17'd1 >= {1'b0, reg_h})
                    begin
                        row = 16'd0;
                        if ({1'b0, col} + 17'd1 >= {1'b0, reg_w})
                        begin
                            col = 16'd0;
                            scanning = 1'b0;
                            r.region_done = 1'b1;
                        end
                        else
                            col = col + 16'd1;
                    end
                    else
                        row = row + 16'd1;
                end
            end
            OP_CLEAR:
            begin
                for (int k = 0; k < NUM_KINDS; k++)
                begin
                    ext_w[k] = 17'd0;
                    ext_h[k] = 17'd0;
                end
            end
            default: ;
        endcase
        r.target_plane = lat_kind;
        if (lat_kind != KIND_NONE)
        begin
            r.extent_width = ext_w[lat_kind];
            r.extent_height = ext_h[lat_kind];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t got, want;
        if (!rst_n)
        begin
            reg_px = '0;
            reg_py = '0;
            reg_w = '0;
            reg_h = '0;
            reg_ux = '0;
            reg_uy = '0;
            lat_kind = KIND_OCC;
            lat_rot = 1'b0;
            col = '0;
            row = '0;
            scanning = 1'b0;
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                ext_w[k] = 17'd0;
                ext_h[k] = 17'd0;
            end
            expected_pairs.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.src_x = m_tdata[16:0];
                got.src_y = m_tdata[33:17];
                got.dst_x = m_tdata[50:34];
                got.dst_y = m_tdata[67:51];
                got.extent_width = m_tdata[84:68];
                got.extent_height = m_tdata[101:85];
                got.pair_valid = m_tuser[0];
                got.target_plane = m_tuser[2:1];
                got.region_done = m_tlast;
                if (expected_pairs.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    check_field("pair_valid", want.pair_valid, got.pair_valid);
                    check_field("src_x", want.src_x, got.src_x);
                    check_field("src_y", want.src_y, got.src_y);
                    check_field("dst_x", want.dst_x, got.dst_x);
                    check_field("dst_y", want.dst_y, got.dst_y);
                    check_field("target_plane", want.target_plane, got.target_plane);
                    check_field("region_done", want.region_done, got.region_done);
                    check_field("extent_width", want.extent_width, got.extent_width);
                    check_field("extent_height", want.extent_height, got.extent_height);
                end
            end
            if (s_tvalid && s_tready)
                expected_pairs.push_back(scan_model(s_tuser[1:0], s_tuser[3:2], s_tdata));
            pending <= expected_pairs.size();
        end
    end

endmodule

@@ tb/sv/tb_region_unpack_address_scanner.sv @@
// Top of the region unpack address scanner testbench: clock, reset, request
// stimulus with random gaps, result back-pressure, watchdog and verdict.
// Depends on rua_pkg, the block itself and rua_scan_checker.
module tb_region_unpack_address_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import rua_pkg::*;

    localparam int N_ITEMS     = 1350;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 20;

    // Op code the block leaves unused; it must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [15:0] px, py, w, h, ux, uy;
        logic        rot;
    } req_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    int mismatches;
    int outstanding;
    int n_tx = 0;
    int n_rx = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    region_unpack_address_scanner DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rua_scan_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (mismatches),
        .pending  (outstanding)
    );

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls, calm stretches, and one long hold-off that
    // lets the queue fill and back-pressure reach the request side.
    initial
    begin : receiver
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = (((n_rx / 170) % 3) == 1) ? 0 : $urandom_range(0, 6);
            if (n_rx == HOLD_AFTER)
                gap = HOLD_CYCLES;
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            n_rx++;
        end
    end

    task automatic send_req(input req_t r);
        int gap;
        gap = (((n_tx / 200) % 3) == 2) ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {r.kind, r.op};
        s_tdata <= {7'd0, r.rot, r.uy, r.ux, r.h, r.w, r.py, r.px};
        do @(posedge clk); while (!s_tready);
        n_tx++;
    endtask

    // Any op with fully random descriptor bits; the block uses only what the op needs.
    task automatic issue(input logic [1:0] op);
        req_t r;
        r.op = op;
        r.kind = 2'($urandom);
        r.px = 16'($urandom);
        r.py = 16'($urandom);
        r.w = 16'($urandom);
        r.h = 16'($urandom);
        r.ux = 16'($urandom);
        r.uy = 16'($urandom);
        r.rot = 1'($urandom);
        send_req(r);
    endtask

    task automatic load_region(input logic [1:0] kind, input logic [15:0] px, py, w, h,
                               input logic [15:0] ux, uy, input logic rot);
        req_t r;
        r.op = OP_LOAD;
        r.kind = kind;
        r.px = px;
        r.py = py;
        r.w = w;
        r.h = h;
        r.ux = ux;
        r.uy = uy;
        r.rot = rot;
        send_req(r);
    endtask

    task automatic run_steps(input int n);
        repeat (n) issue(OP_STEP);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int          pick;
        int          cw, ch;
        logic [15:0] w, h;
        bit          paused;
        paused = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Step with no scan running, then a clear of untouched extents.
        issue(OP_STEP);
        issue(OP_CLEAR);
        // Small occupancy region walked to its end.
        load_region(KIND_OCC, 16'd0, 16'd0, 16'd2, 16'd3, 16'd0, 16'd0, 1'b0);
        run_steps(6);
        // Zero sizes at the top corner, rotated, then a step after the scan is over.
        load_region(KIND_GEO, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        run_steps(2);
        // Largest region pushes the extents to their top; a region of the
        // other kind then abandons the scan without touching the extents.
        load_region(KIND_ATTR, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_steps(2);
        load_region(KIND_NONE, 16'd7, 16'd9, 16'd4, 16'd4, 16'd1, 16'd2, 1'b0);
        issue(OP_STEP);
        // Rotated attribute region with a clear and an unused op in mid-scan.
        load_region(KIND_ATTR, 16'd100, 16'd200, 16'd3, 16'd2, 16'd5, 16'd7, 1'b1);
        run_steps(2);
        issue(OP_CLEAR);
        run_steps(2);
        issue(OP_UNUSED);
        run_steps(2);
        wait_for_results();

        while (n_tx < N_ITEMS)
        begin
            if (!paused && n_tx >= N_ITEMS / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                w = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                h = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                cw = (w == 16'd0) ? 1 : int'(w);
                ch = (h == 16'd0) ? 1 : int'(h);
                load_region(2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom), w, h,
                            16'($urandom), 16'($urandom), 1'($urandom));
                run_steps(cw * ch + $urandom_range(0, 1));
            end
            else if (pick < 82)
            begin
                // Large region, abandoned after a few pairs.
                load_region(2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            1'($urandom));
                run_steps($urandom_range(0, 8));
            end
            else if (pick < 88)
                issue(OP_CLEAR);
            else if (pick < 92)
                issue(OP_UNUSED);
            else if (pick < 96)
            begin
                load_region(KIND_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
                run_steps($urandom_range(0, 2));
            end
            else
                run_steps($urandom_range(1, 3));
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
